### sv/sdf_pkg.sv
// Shared widths, register indexes, stage payload types and helpers for the spring force pipeline
`timescale 1ns / 1ps
`default_nettype none
package sdf_pkg;

    localparam int DIFF_W = 33;   // exact difference of two 32-bit values
    localparam int MAG_W  = 32;   // magnitude of such a difference
    localparam int RAD_W  = 66;   // radicand dx^2 + dy^2, padded to even width
    localparam int ROOT_W = 33;   // distance
    localparam int DOT_W  = 66;   // magnitude of v . d
    localparam int PM_W   = 64;   // projected velocity
    localparam int FQ_W   = 32;   // force quotient bits
    localparam int NUM_W  = 96;   // |coeff| * |d| numerator
    localparam int CFG_W  = 31;

    localparam logic REG_STIFFNESS = 1'b0;
    localparam logic REG_DAMPING   = 1'b1;

    // payload carried alongside the square root
    typedef struct packed {
        logic [DOT_W-1:0]         dot_mag;
        logic                     dot_neg;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [CFG_W-1:0]         rest;
        logic                     pin_a;
        logic                     pin_b;
    } sq_side_t;

    // payload carried alongside the projection divider
    typedef struct packed {
        logic [ROOT_W-1:0]        span;
        logic                     dot_neg;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [CFG_W-1:0]         rest;
        logic                     pin_a;
        logic                     pin_b;
    } dv_side_t;

    // payload carried alongside the x force divider
    typedef struct packed {
        logic neg;
        logic zero;
        logic pin_a;
        logic pin_b;
    } fd_side_t;

    function automatic logic [MAG_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        n = -v;
        return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/spring_damper_force.sv
// Throughput: one spring per cycle while the output is not stalled; the square root
// (33 stages), the projection divider (64 stages) and the force dividers (32 stages)
// are fully pipelined.
// Whole pipeline advances when the output register is empty or being taken.
// Reset (rst_n low, asynchronous) empties the pipeline and sets stiffness to 1.0,
// damping to 0.
`timescale 1ns / 1ps
`default_nettype none
module spring_damper_force #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x,
    // first_vel_y, second_vel_x, second_vel_y, rest_length, first_pinned,
    // second_pinned, zero pad
    input  wire logic [295:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // force_x, force_y, apply_first, apply_second, zero_length, zero pad
    output logic [71:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [30:0]  cfg_data
);

    localparam int DW = sdf_pkg::DIFF_W;

    logic en;
    logic [30:0] stiffness_reg;
    logic [30:0] damping_reg;

    // stage registers
    logic v1_reg, v2_reg, v3_reg, d1v_reg, d2v_reg, d3v_reg, d4v_reg, d5v_reg;
    logic out_valid_reg;
    logic [71:0] out_data_reg;

    logic signed [DW-1:0] dx1_reg, dy1_reg, vx1_reg, vy1_reg;
    logic [30:0] rest1_reg;
    logic pa1_reg, pb1_reg;

    logic [63:0] sqx2_reg, sqy2_reg, ax2_reg, ay2_reg;
    logic an2_reg, bn2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic [30:0] rest2_reg;
    logic pa2_reg, pb2_reg;

    logic [sdf_pkg::RAD_W-1:0] rad3_reg;
    sdf_pkg::sq_side_t sq3_reg;

    // advance every stage together
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= 31'(1) << FRAC_BITS;
            damping_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdf_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                sdf_pkg::REG_DAMPING:   damping_reg   <= cfg_data;
                default:                stiffness_reg <= stiffness_reg;
            endcase
        end
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: exact differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg   <= $signed({s_tdata[31], s_tdata[31:0]})
                       - $signed({s_tdata[95], s_tdata[95:64]});
            dy1_reg   <= $signed({s_tdata[63], s_tdata[63:32]})
                       - $signed({s_tdata[127], s_tdata[127:96]});
            vx1_reg   <= $signed({s_tdata[159], s_tdata[159:128]})
                       - $signed({s_tdata[223], s_tdata[223:192]});
            vy1_reg   <= $signed({s_tdata[191], s_tdata[191:160]})
                       - $signed({s_tdata[255], s_tdata[255:224]});
            rest1_reg <= s_tdata[286:256];
            pa1_reg   <= s_tdata[287];
            pb1_reg   <= s_tdata[288];
        end
    end

    // stage 2: squares and dot product terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx2_reg  <= 64'(sdf_pkg::mag33(dx1_reg)) * 64'(sdf_pkg::mag33(dx1_reg));
            sqy2_reg  <= 64'(sdf_pkg::mag33(dy1_reg)) * 64'(sdf_pkg::mag33(dy1_reg));
            ax2_reg   <= 64'(sdf_pkg::mag33(vx1_reg)) * 64'(sdf_pkg::mag33(dx1_reg));
            ay2_reg   <= 64'(sdf_pkg::mag33(vy1_reg)) * 64'(sdf_pkg::mag33(dy1_reg));
            an2_reg   <= vx1_reg[DW-1] ^ dx1_reg[DW-1];
            bn2_reg   <= vy1_reg[DW-1] ^ dy1_reg[DW-1];
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            rest2_reg <= rest1_reg;
            pa2_reg   <= pa1_reg;
            pb2_reg   <= pb1_reg;
        end
    end

    // stage 3: radicand and signed dot product
    logic signed [66:0] dot_a, dot_b, dot_s, dot_n;
    always_comb
    begin
        dot_a = $signed({3'b000, ax2_reg});
        dot_b = $signed({3'b000, ay2_reg});
        if (an2_reg)
            dot_a = -dot_a;
        if (bn2_reg)
            dot_b = -dot_b;
        dot_s = dot_a + dot_b;
        dot_n = -dot_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad3_reg        <= 66'(sqx2_reg) + 66'(sqy2_reg);
            sq3_reg.dot_neg <= dot_s[66];
            sq3_reg.dot_mag <= dot_s[66] ? dot_n[65:0] : dot_s[65:0];
            sq3_reg.dx      <= dx2_reg;
            sq3_reg.dy      <= dy2_reg;
            sq3_reg.rest    <= rest2_reg;
            sq3_reg.pin_a   <= pa2_reg;
            sq3_reg.pin_b   <= pb2_reg;
        end
    end

    // distance
    logic                        sq_valid;
    logic [sdf_pkg::ROOT_W-1:0]  sq_root;
    sdf_pkg::sq_side_t           sq_side;
    logic [$bits(sdf_pkg::sq_side_t)-1:0] sq_side_bits;

    sdf_sqrt #(
        .RW (sdf_pkg::ROOT_W),
        .SW ($bits(sdf_pkg::sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .rad       (rad3_reg),
        .side_in   (sq3_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side_bits)
    );
    assign sq_side = sq_side_bits;

    // projected velocity (v . d) / distance
    sdf_pkg::dv_side_t dv_in;
    sdf_pkg::dv_side_t dv_side;
    logic [$bits(sdf_pkg::dv_side_t)-1:0] dv_side_bits;
    logic                     dv_valid;
    logic [sdf_pkg::PM_W-1:0] dv_quot;
    logic                     dv_ovf;

    always_comb
    begin
        dv_in.span    = sq_root;
        dv_in.dot_neg = sq_side.dot_neg;
        dv_in.dx      = sq_side.dx;
        dv_in.dy      = sq_side.dy;
        dv_in.rest    = sq_side.rest;
        dv_in.pin_a   = sq_side.pin_a;
        dv_in.pin_b   = sq_side.pin_b;
    end

    sdf_div #(
        .NW (sdf_pkg::DOT_W),
        .DW (sdf_pkg::ROOT_W),
        .QW (sdf_pkg::PM_W),
        .SW ($bits(sdf_pkg::dv_side_t))
    ) u_proj_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (sq_side.dot_mag),
        .den       (sq_root),
        .side_in   (dv_in),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .ovf       (dv_ovf),
        .side_out  (dv_side_bits)
    );
    assign dv_side = dv_side_bits;

    // back stage registers
    logic [33:0] emag_d1_reg;
    logic        eneg_d1_reg;
    logic [62:0] dlo_d1_reg, dhi_d1_reg;
    logic        dn_d1_reg, zero_d1_reg, pa_d1_reg, pb_d1_reg;
    logic signed [DW-1:0] dx_d1_reg, dy_d1_reg;
    logic [sdf_pkg::ROOT_W-1:0] dist_d1_reg;

    logic [63:0] sm_d2_reg;
    logic [62:0] dm_d2_reg;
    logic        eneg_d2_reg, dn_d2_reg, zero_d2_reg, pa_d2_reg, pb_d2_reg;
    logic signed [DW-1:0] dx_d2_reg, dy_d2_reg;
    logic [sdf_pkg::ROOT_W-1:0] dist_d2_reg;

    logic [62:0] cmag_d3_reg;
    logic        cneg_d3_reg, zero_d3_reg, pa_d3_reg, pb_d3_reg;
    logic signed [DW-1:0] dx_d3_reg, dy_d3_reg;
    logic [sdf_pkg::ROOT_W-1:0] dist_d3_reg;

    logic [63:0] pxl_d4_reg, pxh_d4_reg, pyl_d4_reg, pyh_d4_reg;
    logic        nx_d4_reg, ny_d4_reg, zero_d4_reg, pa_d4_reg, pb_d4_reg;
    logic [sdf_pkg::ROOT_W-1:0] dist_d4_reg;

    logic [sdf_pkg::NUM_W-1:0] nx_d5_reg, ny_d5_reg;
    sdf_pkg::fd_side_t fdx_d5_reg;
    logic        ny_neg_d5_reg;
    logic [sdf_pkg::ROOT_W-1:0] dist_d5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1v_reg <= 1'b0;
            d2v_reg <= 1'b0;
            d3v_reg <= 1'b0;
            d4v_reg <= 1'b0;
            d5v_reg <= 1'b0;
        end
        else if (en)
        begin
            d1v_reg <= dv_valid;
            d2v_reg <= d1v_reg;
            d3v_reg <= d2v_reg;
            d4v_reg <= d3v_reg;
            d5v_reg <= d4v_reg;
        end
    end

    // D1: length error and damping partial products
    logic signed [34:0] err;
    logic signed [34:0] err_n;
    logic [63:0]        pm;
    always_comb
    begin
        err   = $signed({2'b00, dv_side.span}) - $signed({4'b0000, dv_side.rest});
        err_n = -err;
        pm    = dv_ovf ? '1 : dv_quot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            emag_d1_reg <= err[34] ? err_n[33:0] : err[33:0];
            eneg_d1_reg <= err[34];
            dlo_d1_reg  <= 63'(damping_reg) * 63'(pm[31:0]);
            dhi_d1_reg  <= 63'(damping_reg) * 63'(pm[63:32]);
            dn_d1_reg   <= dv_side.dot_neg;
            zero_d1_reg <= (dv_side.span == '0);
            pa_d1_reg   <= dv_side.pin_a;
            pb_d1_reg   <= dv_side.pin_b;
            dx_d1_reg   <= dv_side.dx;
            dy_d1_reg   <= dv_side.dy;
            dist_d1_reg <= dv_side.span;
        end
    end

    // D2: spring term and capped damping term magnitudes
    logic [64:0] sprod;
    logic [94:0] dprod;
    logic [94:0] dshift;
    localparam logic [94:0] DAMP_CAP = 95'(1) << 62;
    always_comb
    begin
        sprod  = 65'(stiffness_reg) * 65'(emag_d1_reg);
        dprod  = 95'(dlo_d1_reg) + (95'(dhi_d1_reg) << 32);
        dshift = dprod >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_d2_reg   <= 64'(sprod >> FRAC_BITS);
            dm_d2_reg   <= (dshift > DAMP_CAP) ? DAMP_CAP[62:0] : dshift[62:0];
            eneg_d2_reg <= eneg_d1_reg;
            dn_d2_reg   <= dn_d1_reg;
            zero_d2_reg <= zero_d1_reg;
            pa_d2_reg   <= pa_d1_reg;
            pb_d2_reg   <= pb_d1_reg;
            dx_d2_reg   <= dx_d1_reg;
            dy_d2_reg   <= dy_d1_reg;
            dist_d2_reg <= dist_d1_reg;
        end
    end

    // D3: coefficient = -(spring + damping)
    logic signed [64:0] st, dt, csum, csum_n;
    always_comb
    begin
        st = $signed({1'b0, sm_d2_reg});
        dt = $signed({2'b00, dm_d2_reg});
        if (eneg_d2_reg)
            st = -st;
        if (dn_d2_reg)
            dt = -dt;
        csum   = st + dt;
        csum_n = -csum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // coefficient is negative exactly when the sum is positive
            cneg_d3_reg <= !csum[64] && (csum != '0);
            cmag_d3_reg <= csum[64] ? csum_n[62:0] : csum[62:0];
            zero_d3_reg <= zero_d2_reg;
            pa_d3_reg   <= pa_d2_reg;
            pb_d3_reg   <= pb_d2_reg;
            dx_d3_reg   <= dx_d2_reg;
            dy_d3_reg   <= dy_d2_reg;
            dist_d3_reg <= dist_d2_reg;
        end
    end

    // D4: coefficient times direction, split partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxl_d4_reg  <= 64'(cmag_d3_reg[31:0]) * 64'(sdf_pkg::mag33(dx_d3_reg));
            pxh_d4_reg  <= 64'(cmag_d3_reg[62:32]) * 64'(sdf_pkg::mag33(dx_d3_reg));
            pyl_d4_reg  <= 64'(cmag_d3_reg[31:0]) * 64'(sdf_pkg::mag33(dy_d3_reg));
            pyh_d4_reg  <= 64'(cmag_d3_reg[62:32]) * 64'(sdf_pkg::mag33(dy_d3_reg));
            nx_d4_reg   <= cneg_d3_reg ^ dx_d3_reg[DW-1];
            ny_d4_reg   <= cneg_d3_reg ^ dy_d3_reg[DW-1];
            zero_d4_reg <= zero_d3_reg;
            pa_d4_reg   <= pa_d3_reg;
            pb_d4_reg   <= pb_d3_reg;
            dist_d4_reg <= dist_d3_reg;
        end
    end

    // D5: combine partial products into the force numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_d5_reg        <= 96'(pxl_d4_reg) + (96'(pxh_d4_reg) << 32);
            ny_d5_reg        <= 96'(pyl_d4_reg) + (96'(pyh_d4_reg) << 32);
            fdx_d5_reg.neg   <= nx_d4_reg;
            fdx_d5_reg.zero  <= zero_d4_reg;
            fdx_d5_reg.pin_a <= pa_d4_reg;
            fdx_d5_reg.pin_b <= pb_d4_reg;
            ny_neg_d5_reg    <= ny_d4_reg;
            dist_d5_reg      <= dist_d4_reg;
        end
    end

    // force dividers
    logic                      fx_valid, fy_valid, fx_ovf, fy_ovf, fy_neg;
    logic [sdf_pkg::FQ_W-1:0]  fx_quot, fy_quot;
    logic [$bits(sdf_pkg::fd_side_t)-1:0] fx_side_bits;
    sdf_pkg::fd_side_t         fx_side;

    sdf_div #(
        .NW (sdf_pkg::NUM_W),
        .DW (sdf_pkg::ROOT_W),
        .QW (sdf_pkg::FQ_W),
        .SW ($bits(sdf_pkg::fd_side_t))
    ) u_fx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d5v_reg),
        .num       (nx_d5_reg),
        .den       (dist_d5_reg),
        .side_in   (fdx_d5_reg),
        .out_valid (fx_valid),
        .quot      (fx_quot),
        .ovf       (fx_ovf),
        .side_out  (fx_side_bits)
    );
    assign fx_side = fx_side_bits;

    sdf_div #(
        .NW (sdf_pkg::NUM_W),
        .DW (sdf_pkg::ROOT_W),
        .QW (sdf_pkg::FQ_W),
        .SW (1)
    ) u_fy_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d5v_reg),
        .num       (ny_d5_reg),
        .den       (dist_d5_reg),
        .side_in   (ny_neg_d5_reg),
        .out_valid (fy_valid),
        .quot      (fy_quot),
        .ovf       (fy_ovf),
        .side_out  (fy_neg)
    );

    // saturate each component to the signed 32-bit range
    function automatic logic [31:0] sat_force(input logic neg, input logic ovf,
                                              input logic [31:0] q);
        logic big;
        big = ovf || q[31];
        if (neg)
            return big ? 32'h8000_0000 : (32'd0 - q);
        return big ? 32'h7FFF_FFFF : q;
    endfunction

    logic [31:0] fx_out, fy_out;
    always_comb
    begin
        fx_out = sat_force(fx_side.neg, fx_ovf, fx_quot);
        fy_out = sat_force(fy_neg, fy_ovf, fy_quot);
        if (fx_side.zero)
        begin
            fx_out = '0;
            fy_out = '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {5'b00000, fx_side.zero, !fx_side.pin_b, !fx_side.pin_a,
                             fy_out, fx_out};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fx_valid == fy_valid)
        else $error("force dividers out of step");

    a_zero_gives_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66] |-> m_tdata[63:0] == 64'd0)
        else $error("zero length beat carries a force");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en && fx_valid |=> fx_valid && $stable(fx_quot))
        else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

### sv/sdf_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a payload riding along
`timescale 1ns / 1ps
`default_nettype none
module sdf_sqrt #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2*RW-1:0] rad,
    input  wire logic [SW-1:0]   side_in,
    output logic                 out_valid,
    output logic [RW-1:0]        root,
    output logic [SW-1:0]        side_out
);

    localparam int REM_W = RW + 2;

    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [2*RW-1:0]  rad_reg  [RW];
    logic [SW-1:0]    side_reg [RW];
    logic [RW-1:0]    valid_reg;

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_prev;
        logic [RW-1:0]    root_prev;
        logic [2*RW-1:0]  rad_prev;
        logic [SW-1:0]    side_prev;
        logic             vld_prev;
        logic [REM_W+1:0] rem4;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign side_prev = side_in;
            assign vld_prev  = in_valid;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = valid_reg[k-1];
        end

        // bring down the next two radicand bits and try a one in the root
        assign rem4  = {rem_prev, rad_prev[2*RW-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (rem4 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REM_W'(rem4 - trial) : REM_W'(rem4);
                root_reg[k] <= {root_prev[RW-2:0], ge};
                rad_reg[k]  <= rad_prev << 2;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule
`default_nettype wire

### sv/sdf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and payload
`timescale 1ns / 1ps
`default_nettype none
module sdf_div #(
    parameter int NW = 96,
    parameter int DW = 33,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quot,
    output logic               ovf,
    output logic [SW-1:0]      side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] qn_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] ovf_reg;
    logic [QW-1:0] valid_reg;
    logic [NW-QW-1:0] num_hi;
    logic          ovf_in;

    // quotient does not fit (or divisor is zero) when the top part reaches the divisor
    assign num_hi = num[NW-1:QW];
    assign ovf_in = (num_hi >= den);

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [QW-1:0] qn_prev;
        logic [SW-1:0] side_prev;
        logic          ovf_prev;
        logic          vld_prev;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_prev  = DW'(num_hi);
            assign den_prev  = den;
            assign qn_prev   = num[QW-1:0];
            assign side_prev = side_in;
            assign ovf_prev  = ovf_in;
            assign vld_prev  = in_valid;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign qn_prev   = qn_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign ovf_prev  = ovf_reg[k-1];
            assign vld_prev  = valid_reg[k-1];
        end

        // shift in the next numerator bit, subtract where it fits
        assign trial = {rem_prev, qn_prev[QW-1]};
        assign ge    = (trial >= {1'b0, den_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
                qn_reg[k]   <= {qn_prev[QW-2:0], ge};
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
                ovf_reg[k]  <= ovf_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = qn_reg[QW-1];
    assign ovf       = ovf_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule
`default_nettype wire
